FILE: rtl/core/package_stanza_field_locator_unit_assert.svh
// Assertion helpers for the stanza field locator.
// Define ASSERT_OFF to compile the checks away.
`ifndef PACKAGE_STANZA_FIELD_LOCATOR_UNIT_ASSERT_SVH
`define PACKAGE_STANZA_FIELD_LOCATOR_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define PSFL_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
		else $error("psfl: assertion failed");
`define PSFL_ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
		else $error("psfl: forbidden condition");
`else
`define PSFL_ASSERT(lbl, clk, rstn, prop)
`define PSFL_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

FILE: rtl/core/psfl_pkg.sv
package psfl_pkg;

	localparam int OUT_W = 32;

	typedef enum logic [2:0] {
		PH_RESET,
		PH_NLINE,
		PH_PDATA,
		PH_EXPECT,
		PH_DELIM,
		PH_VER,
		PH_PKG,
		PH_STAT
	} phase_t;

	typedef enum logic [1:0] {
		KW_NONE,
		KW_VER,
		KW_PKG,
		KW_STAT
	} kw_t;

	typedef enum logic [2:0] {
		ERR_NONE,
		ERR_NO_NAME,
		ERR_NO_VER,
		ERR_DUP_PKG,
		ERR_DUP_VER,
		ERR_DUP_STAT,
		ERR_UNTERM
	} err_t;

	localparam logic [7:0] CH_NL  = 8'h0A;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_V   = 8'h56;
	localparam logic [7:0] CH_P   = 8'h50;
	localparam logic [7:0] CH_S   = 8'h53;

	// keyword tails after the leading capital, zero padded
	localparam logic [0:7][7:0]  KW_VER_TXT  = {"ersion:", 8'h00};
	localparam logic [0:7][7:0]  KW_PKG_TXT  = {"ackage:", 8'h00};
	localparam logic [0:15][7:0] KW_STAT_TXT = {"tatus: install ", 8'h00};

	localparam logic [3:0] KW_SHORT_LEN = 4'd7;
	localparam logic [3:0] KW_STAT_LEN  = 4'd15;

	// classified input beat
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       nl;
		logic       ws;
		kw_t        kw;
	} item_t;

	typedef struct packed {
		logic             is_error;
		err_t             code;
		logic [OUT_W-1:0] name_off;
		logic [OUT_W-1:0] name_len;
		logic [OUT_W-1:0] ver_off;
		logic [OUT_W-1:0] ver_len;
		logic             has_status;
	} res_t;

	function automatic logic [3:0] kw_len(kw_t k);
		return (k == KW_STAT) ? KW_STAT_LEN : KW_SHORT_LEN;
	endfunction

	function automatic logic [7:0] kw_char(kw_t k, logic [3:0] idx);
		logic [7:0] c;
		unique case (k)
			KW_VER:  c = KW_VER_TXT[idx[2:0]];
			KW_PKG:  c = KW_PKG_TXT[idx[2:0]];
			KW_STAT: c = KW_STAT_TXT[idx];
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/core/psfl_front.sv
module psfl_front #(
	parameter int POS_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [7:0]          in_data,
	input  logic                in_last,
	input  logic                q_full,
	output logic                in_ready,
	output logic                q_push,
	output psfl_pkg::item_t     q_item,
	output logic [POS_BITS-1:0] q_pos
);
	import psfl_pkg::*;

	logic [POS_BITS-1:0] pos_q;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;
	assign q_pos    = pos_q;

	always_comb begin
		q_item.data = in_data;
		q_item.last = in_last;
		q_item.nl   = (in_data == CH_NL);
		q_item.ws   = (in_data == CH_SP) || ((in_data >= CH_TAB) && (in_data <= CH_CR));
		unique case (in_data)
			CH_V:    q_item.kw = KW_VER;
			CH_P:    q_item.kw = KW_PKG;
			CH_S:    q_item.kw = KW_STAT;
			default: q_item.kw = KW_NONE;
		endcase
	end

	// stream position restarts after the final beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (q_push) begin
			pos_q <= in_last ? '0 : pos_q + 1'b1;
		end
	end

endmodule

FILE: rtl/core/psfl_fifo.sv
module psfl_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic         full,
	output logic         valid,
	output logic [W-1:0] rdata
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [W-1:0]  mem [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == FULL_CNT);
	assign valid = (count_q != '0);
	assign rdata = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/psfl_back.sv
`include "package_stanza_field_locator_unit_assert.svh"

module psfl_back #(
	parameter int POS_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  logic                q_valid,
	input  psfl_pkg::item_t     q_item,
	input  logic [POS_BITS-1:0] q_pos,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output psfl_pkg::res_t      out_res
);
	import psfl_pkg::*;

	logic                mode_q;
	phase_t              phase_q,  phase_n;
	logic [3:0]          match_q,  match_n;
	kw_t                 pkw_q,    pkw_n;
	logic [POS_BITS-1:0] vstart_q, vstart_n;
	logic [POS_BITS-1:0] nstart_q, nstart_n;
	logic [POS_BITS-1:0] nspan_q,  nspan_n;
	logic                nseen_q,  nseen_n;
	logic [POS_BITS-1:0] rstart_q, rstart_n;
	logic [POS_BITS-1:0] rspan_q,  rspan_n;
	logic                rseen_q,  rseen_n;
	logic                sseen_q,  sseen_n;
	logic                ehold_q,  ehold_n;

	logic                back_rdy;
	logic                err_c;
	err_t                ecode_c;
	logic                res_v;
	res_t                res;
	logic [3:0]          klen;
	logic [3:0]          midx_inc;
	logic [POS_BITS-1:0] span_c;
	logic                out_valid_q;
	res_t                out_res_q;

	assign back_rdy  = !out_valid_q || out_ready;
	assign q_pop     = q_valid && back_rdy;
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	assign klen     = kw_len(pkw_q);
	assign midx_inc = match_q + 1'b1;
	assign span_c   = q_pos - vstart_q;

	always_comb begin
		phase_n  = phase_q;
		match_n  = match_q;
		pkw_n    = pkw_q;
		vstart_n = vstart_q;
		nstart_n = nstart_q;
		nspan_n  = nspan_q;
		nseen_n  = nseen_q;
		rstart_n = rstart_q;
		rspan_n  = rspan_q;
		rseen_n  = rseen_q;
		sseen_n  = sseen_q;
		ehold_n  = ehold_q;
		err_c    = 1'b0;
		ecode_c  = ERR_NONE;
		res_v    = 1'b0;
		res      = '0;

		if (q_pop) begin
			if (!ehold_q) begin
				if (q_item.nl) begin
					unique case (phase_q)
						PH_RESET: ;
						PH_NLINE: begin
							// blank line closes the record
							if (!nseen_q || nspan_q == '0) begin
								err_c   = 1'b1;
								ecode_c = ERR_NO_NAME;
							end else if ((!rseen_q || rspan_q == '0) && !mode_q) begin
								err_c   = 1'b1;
								ecode_c = ERR_NO_VER;
							end else begin
								if (!mode_q || sseen_q) begin
									res_v          = 1'b1;
									res.name_off   = OUT_W'(nstart_q);
									res.name_len   = OUT_W'(nspan_q);
									res.ver_off    = OUT_W'(rstart_q);
									res.ver_len    = OUT_W'(rspan_q);
									res.has_status = sseen_q;
								end
								nstart_n = '0;
								nspan_n  = '0;
								nseen_n  = 1'b0;
								rstart_n = '0;
								rspan_n  = '0;
								rseen_n  = 1'b0;
								sseen_n  = 1'b0;
								phase_n  = PH_RESET;
							end
						end
						PH_PKG: begin
							if (nseen_q) begin
								err_c   = 1'b1;
								ecode_c = ERR_DUP_PKG;
							end else begin
								nstart_n = vstart_q;
								nspan_n  = span_c;
								nseen_n  = 1'b1;
								phase_n  = PH_NLINE;
							end
						end
						PH_VER: begin
							if (rseen_q) begin
								err_c   = 1'b1;
								ecode_c = ERR_DUP_VER;
							end else begin
								rstart_n = vstart_q;
								rspan_n  = span_c;
								rseen_n  = 1'b1;
								phase_n  = PH_NLINE;
							end
						end
						PH_STAT: begin
							if (sseen_q) begin
								err_c   = 1'b1;
								ecode_c = ERR_DUP_STAT;
							end else begin
								sseen_n = 1'b1;
								phase_n = PH_NLINE;
							end
						end
						default: phase_n = PH_NLINE;
					endcase
				end else begin
					unique case (phase_q)
						PH_RESET, PH_NLINE: begin
							match_n = '0;
							if (q_item.kw != KW_NONE) begin
								phase_n = PH_EXPECT;
								pkw_n   = q_item.kw;
							end else begin
								phase_n = PH_PDATA;
							end
						end
						PH_EXPECT: begin
							if (match_q < klen && q_item.data == kw_char(pkw_q, match_q)) begin
								match_n = midx_inc;
								if (midx_inc >= klen) begin
									phase_n  = PH_DELIM;
									vstart_n = q_pos + 1'b1;
								end
							end else begin
								phase_n = PH_PDATA;
							end
						end
						PH_DELIM: begin
							if (q_item.ws) begin
								vstart_n = vstart_q + 1'b1;
							end else begin
								unique case (pkw_q)
									KW_VER:  phase_n = PH_VER;
									KW_PKG:  phase_n = PH_PKG;
									default: phase_n = PH_STAT;
								endcase
							end
						end
						default: ;
					endcase
				end
			end

			// final beat: flag an open record, then return to reset
			if (q_item.last) begin
				if (!res_v && !err_c && !ehold_q && phase_n != PH_RESET) begin
					err_c   = 1'b1;
					ecode_c = ERR_UNTERM;
				end
				phase_n  = PH_RESET;
				match_n  = '0;
				pkw_n    = KW_NONE;
				vstart_n = '0;
				nstart_n = '0;
				nspan_n  = '0;
				nseen_n  = 1'b0;
				rstart_n = '0;
				rspan_n  = '0;
				rseen_n  = 1'b0;
				sseen_n  = 1'b0;
			end

			if (err_c) begin
				res_v        = 1'b1;
				res          = '0;
				res.is_error = 1'b1;
				res.code     = ecode_c;
			end
			ehold_n = (ehold_q || err_c) && !q_item.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			phase_q  <= PH_RESET;
			match_q  <= '0;
			pkw_q    <= KW_NONE;
			vstart_q <= '0;
			nstart_q <= '0;
			nspan_q  <= '0;
			nseen_q  <= 1'b0;
			rstart_q <= '0;
			rspan_q  <= '0;
			rseen_q  <= 1'b0;
			sseen_q  <= 1'b0;
			ehold_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			phase_q  <= phase_n;
			match_q  <= match_n;
			pkw_q    <= pkw_n;
			vstart_q <= vstart_n;
			nstart_q <= nstart_n;
			nspan_q  <= nspan_n;
			nseen_q  <= nseen_n;
			rstart_q <= rstart_n;
			rspan_q  <= rspan_n;
			rseen_q  <= rseen_n;
			sseen_q  <= sseen_n;
			ehold_q  <= ehold_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (back_rdy) begin
			out_valid_q <= res_v;
		end
	end

	always_ff @(posedge clk) begin
		if (back_rdy && res_v) begin
			out_res_q <= res;
		end
	end

	`PSFL_ASSERT(a_err_has_code, clk, arst_n, (out_valid_q && out_res_q.is_error) |-> (out_res_q.code != ERR_NONE))
	`PSFL_ASSERT(a_rec_has_name, clk, arst_n, (out_valid_q && !out_res_q.is_error) |-> (out_res_q.code == ERR_NONE && nseen_q == 1'b0))
	`PSFL_ASSERT(a_last_clears, clk, arst_n, (q_pop && q_item.last) |=> (phase_q == PH_RESET && !ehold_q && !nseen_q && !rseen_q && !sseen_q))
	`PSFL_ASSERT_NEVER(a_kw_pending, clk, arst_n, (phase_q == PH_EXPECT || phase_q == PH_DELIM || phase_q == PH_VER || phase_q == PH_PKG || phase_q == PH_STAT) && pkw_q == KW_NONE)

endmodule

FILE: rtl/core/package_stanza_field_locator_unit.sv
// Package stanza field locator.
// Input stream (s_*): one text byte per beat in s_tdata, s_tlast marks the
// final byte of a file. Output stream (m_*): one beat per completed record
// or parse error; m_tuser is the error flag, m_tdata carries the code and
// the byte offsets and lengths of the Package and Version values.
// cfg_we/cfg_wdata set status mode (installed-status file); write it only
// while the block is idle.
// Throughput: one byte per cycle while m_tready is not stalling. Each byte
// is one step of the parser state machine in the back end; the front end
// tags bytes with their stream position and pushes them into a four-entry
// queue. A result is registered onto m_* after the byte that closes the
// record (or raises the error) leaves the queue and is parsed; bytes still
// queued ahead of it are parsed first.
// Reset clears the parse state, position counter, queue and status mode.
// A stalled m_tready holds the output beat; the queue absorbs up to four
// more bytes before s_tready drops. No clearing pass after reset.
module package_stanza_field_locator_unit #(
	parameter int POS_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  logic         s_tlast,   // last_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	// [2:0] error_code, [34:3] name_offset, [66:35] name_length,
	// [98:67] version_offset, [130:99] version_length, [131] has_status
	output logic [135:0] m_tdata,
	output logic         m_tuser,   // is_error
	input  logic         cfg_we,
	input  logic         cfg_wdata
);
	import psfl_pkg::*;

	localparam int QDEPTH = 4;
	localparam int IW     = $bits(item_t);
	localparam int QW     = IW + POS_BITS;

	logic                q_push;
	logic                q_full;
	logic                q_valid;
	logic                q_pop;
	item_t               fe_item;
	logic [POS_BITS-1:0] fe_pos;
	logic [QW-1:0]       q_rdata;
	item_t               be_item;
	logic [POS_BITS-1:0] be_pos;
	res_t                res;

	psfl_front #(.POS_BITS(POS_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_data  (s_tdata),
		.in_last  (s_tlast),
		.q_full   (q_full),
		.in_ready (s_tready),
		.q_push   (q_push),
		.q_item   (fe_item),
		.q_pos    (fe_pos)
	);

	psfl_fifo #(.W(QW), .DEPTH(QDEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  ({fe_pos, fe_item}),
		.pop    (q_pop),
		.full   (q_full),
		.valid  (q_valid),
		.rdata  (q_rdata)
	);

	assign be_item = item_t'(q_rdata[IW-1:0]);
	assign be_pos  = q_rdata[QW-1:IW];

	psfl_back #(.POS_BITS(POS_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_item    (be_item),
		.q_pos     (be_pos),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tuser = res.is_error;
	assign m_tdata = {4'b0000, res.has_status, res.ver_len, res.ver_off,
		res.name_len, res.name_off, res.code};

endmodule

FILE: dv/stanza_span_check.sv
`timescale 1ns / 1ps
module stanza_span_check (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [7:0]   s_tdata,
	input  logic         s_tlast,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [135:0] m_tdata,
	input  logic         m_tuser,
	input  logic         cfg_we,
	input  logic         cfg_wdata,
	output int           fails,
	output int           records_open,
	output int           results_seen
);
	import psfl_pkg::*;

	// keyword tails after the leading capital, first character in the top byte
	localparam logic [55:0]  VER_TAIL  = "ersion:";
	localparam logic [55:0]  PKG_TAIL  = "ackage:";
	localparam logic [119:0] STAT_TAIL = "tatus: install ";

	logic        status_mode;
	phase_t      phase;
	logic [3:0]  match_idx;
	kw_t         pend_kw;
	logic [31:0] pos;
	logic [31:0] val_start;
	logic [31:0] name_start;
	logic [31:0] name_span;
	logic [31:0] ver_start;
	logic [31:0] ver_span;
	logic        name_seen;
	logic        ver_seen;
	logic        status_seen;
	logic        err_hold;
	logic        emitted;
	res_t        pending_records[$];

	function automatic logic [7:0] tail_char(kw_t k, int idx);
		case (k)
			KW_VER:  return VER_TAIL[8*(6-idx) +: 8];
			KW_PKG:  return PKG_TAIL[8*(6-idx) +: 8];
			default: return STAT_TAIL[8*(14-idx) +: 8];
		endcase
	endfunction

	task automatic clear_record();
		name_start  = '0;
		name_span   = '0;
		name_seen   = 1'b0;
		ver_start   = '0;
		ver_span    = '0;
		ver_seen    = 1'b0;
		status_seen = 1'b0;
	endtask

	task automatic clear_parse();
		clear_record();
		phase     = PH_RESET;
		match_idx = '0;
		pend_kw   = KW_NONE;
		pos       = '0;
		val_start = '0;
		err_hold  = 1'b0;
	endtask

	task automatic flag_error(err_t code);
		res_t r;
		r = '0;
		r.is_error = 1'b1;
		r.code = code;
		pending_records.push_back(r);
		err_hold = 1'b1;
		emitted = 1'b1;
	endtask

	task automatic close_line();
		res_t r;
		case (phase)
			PH_RESET: ;
			PH_NLINE: begin
				if (!name_seen || name_span == 0)
					flag_error(ERR_NO_NAME);
				else if ((!ver_seen || ver_span == 0) && !status_mode)
					flag_error(ERR_NO_VER);
				else begin
					// status mode drops records without a status line
					if (!status_mode || status_seen) begin
						r = '0;
						r.code       = ERR_NONE;
						r.name_off   = name_start;
						r.name_len   = name_span;
						r.ver_off    = ver_seen ? ver_start : '0;
						r.ver_len    = ver_seen ? ver_span : '0;
						r.has_status = status_seen;
						pending_records.push_back(r);
						emitted = 1'b1;
					end
					clear_record();
					phase = PH_RESET;
				end
			end
			PH_PKG: begin
				if (name_seen)
					flag_error(ERR_DUP_PKG);
				else begin
					name_start = val_start;
					name_span  = pos - val_start;
					name_seen  = 1'b1;
					phase      = PH_NLINE;
				end
			end
			PH_VER: begin
				if (ver_seen)
					flag_error(ERR_DUP_VER);
				else begin
					ver_start = val_start;
					ver_span  = pos - val_start;
					ver_seen  = 1'b1;
					phase     = PH_NLINE;
				end
			end
			PH_STAT: begin
				if (status_seen)
					flag_error(ERR_DUP_STAT);
				else begin
					status_seen = 1'b1;
					phase       = PH_NLINE;
				end
			end
			default: phase = PH_NLINE;
		endcase
	endtask

	task automatic scan_text(logic [7:0] c);
		int len;
		case (phase)
			PH_RESET, PH_NLINE: begin
				match_idx = '0;
				if (c == CH_V) begin
					phase   = PH_EXPECT;
					pend_kw = KW_VER;
				end else if (c == CH_P) begin
					phase   = PH_EXPECT;
					pend_kw = KW_PKG;
				end else if (c == CH_S) begin
					phase   = PH_EXPECT;
					pend_kw = KW_STAT;
				end else
					phase = PH_PDATA;
			end
			PH_EXPECT: begin
				len = (pend_kw == KW_STAT) ? 15 : 7;
				if (match_idx < len && c == tail_char(pend_kw, match_idx)) begin
					match_idx = match_idx + 1'b1;
					if (match_idx >= len) begin
						phase     = PH_DELIM;
						val_start = pos + 1;
					end
				end else
					phase = PH_PDATA;
			end
			PH_DELIM: begin
				if (c == CH_SP || (c >= CH_TAB && c <= CH_CR))
					val_start = val_start + 1;
				else begin
					case (pend_kw)
						KW_VER:  phase = PH_VER;
						KW_PKG:  phase = PH_PKG;
						default: phase = PH_STAT;
					endcase
				end
			end
			default: ;
		endcase
	endtask

	task automatic parse_byte(logic [7:0] c, logic is_last);
		emitted = 1'b0;
		if (!err_hold) begin
			if (c == CH_NL)
				close_line();
			else
				scan_text(c);
		end
		pos = pos + 1;
		if (is_last) begin
			if (!emitted && !err_hold && phase != PH_RESET)
				flag_error(ERR_UNTERM);
			clear_parse();
		end
	endtask

	task automatic check_field(string what, logic [31:0] want, logic [31:0] seen);
		if (want !== seen) begin
			$display("%0t: result beat %0d, %s expected %0d actual %0d",
				$time, results_seen, what, want, seen);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t seen;
		res_t want;
		if (!arst_n) begin
			status_mode = 1'b0;
			clear_parse();
			pending_records.delete();
			fails        = 0;
			records_open = 0;
			results_seen = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen.is_error   = m_tuser;
				seen.code       = err_t'(m_tdata[2:0]);
				seen.name_off   = m_tdata[34:3];
				seen.name_len   = m_tdata[66:35];
				seen.ver_off    = m_tdata[98:67];
				seen.ver_len    = m_tdata[130:99];
				seen.has_status = m_tdata[131];
				if (pending_records.size() == 0) begin
					$display("%0t: unexpected result beat, expected none actual err=%0d code=%0d",
						$time, seen.is_error, seen.code);
					fails++;
				end else begin
					want = pending_records.pop_front();
					check_field("is_error", want.is_error, seen.is_error);
					check_field("error_code", want.code, seen.code);
					check_field("name_offset", want.name_off, seen.name_off);
					check_field("name_length", want.name_len, seen.name_len);
					check_field("version_offset", want.ver_off, seen.ver_off);
					check_field("version_length", want.ver_len, seen.ver_len);
					check_field("has_status", want.has_status, seen.has_status);
				end
				results_seen++;
			end
			if (s_tvalid && s_tready)
				parse_byte(s_tdata, s_tlast);
			if (cfg_we)
				status_mode = cfg_wdata;
			records_open = pending_records.size();
		end
	end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import psfl_pkg::*;

	typedef enum {LN_PKG, LN_VER, LN_STAT, LN_EMPTY, LN_OTHER, LN_GARBAGE} line_kind_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready;
	logic [135:0] m_tdata;
	logic         m_tuser;
	logic         cfg_we;
	logic         cfg_wdata;

	int   fails;
	int   records_open;
	int   results_seen;
	bit   calm;
	logic mode_now;
	int   bytes_sent;
	logic [7:0] text_q[$];
	logic [7:0] ws_set[5] = '{8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D};

	package_stanza_field_locator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	stanza_span_check span_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tlast      (s_tlast),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.fails        (fails),
		.records_open (records_open),
		.results_seen (results_seen)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		m_tready = 1'b1;
		forever begin
			@(negedge clk);
			m_tready = calm || ($urandom_range(99) >= 8);
		end
	end

	initial begin
		#2_000_000;
		$display("package_stanza_field_locator_unit regression: fail");
		$finish;
	end

	task automatic put_text(string s);
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endtask

	task automatic put_ws();
		repeat ($urandom_range(0, 2))
			text_q.push_back(ws_set[$urandom_range(4)]);
	endtask

	task automatic put_value();
		logic [7:0] b;
		repeat ($urandom_range(1, 6)) begin
			if ($urandom_range(9) == 0)
				b = 8'($urandom_range(255));
			else
				b = 8'($urandom_range(33, 126));
			if (b == CH_NL)
				b = 8'hFF;
			text_q.push_back(b);
		end
	endtask

	// one beat per byte, last beat flagged; valid drops once the stream is out
	task automatic send_stream();
		for (int i = 0; i < text_q.size(); i++) begin
			while (!calm && $urandom_range(99) < 8) begin
				s_tvalid = 1'b0;
				@(negedge clk);
			end
			s_tvalid = 1'b1;
			s_tdata  = text_q[i];
			s_tlast  = (i == text_q.size() - 1);
			do @(posedge clk); while (!s_tready);
			@(negedge clk);
		end
		s_tvalid = 1'b0;
		s_tlast  = 1'b0;
		bytes_sent += text_q.size();
		text_q.delete();
	endtask

	task automatic directed(string s);
		put_text(s);
		send_stream();
	endtask

	task automatic set_mode(logic m);
		s_tvalid = 1'b0;
		wait (records_open == 0);
		// bytes that give no result may still sit in the input queue
		repeat (8) @(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = m;
		@(negedge clk);
		cfg_we   = 1'b0;
		mode_now = m;
	endtask

	task automatic put_line(line_kind_t kind);
		case (kind)
			LN_PKG: begin
				put_text("Package:");
				put_ws();
				put_value();
			end
			LN_VER: begin
				put_text("Version:");
				put_ws();
				put_value();
			end
			LN_STAT: begin
				put_text("Status: install ");
				put_ws();
				if ($urandom_range(1))
					put_text("ok installed");
				else
					put_value();
			end
			LN_EMPTY: begin
				case ($urandom_range(2))
					0: put_text("Package:");
					1: put_text("Version:");
					default: put_text("Status: install ");
				endcase
				put_ws();
			end
			LN_OTHER: begin
				case ($urandom_range(4))
					0: put_text("Description: ");
					1: put_text("Pack");
					2: put_text(" Package: ");
					3: put_text("Status: deinstall ");
					default: put_text("Versio");
				endcase
				put_value();
			end
			default: begin
				repeat ($urandom_range(3, 12))
					text_q.push_back(8'($urandom_range(255)));
			end
		endcase
		text_q.push_back(CH_NL);
	endtask

	task automatic put_record(bit broken);
		line_kind_t lines[$];
		line_kind_t t;
		int j;
		lines.push_back(LN_PKG);
		if (!mode_now || $urandom_range(1))
			lines.push_back(LN_VER);
		if (mode_now ? ($urandom_range(9) != 0) : ($urandom_range(4) == 0))
			lines.push_back(LN_STAT);
		repeat ($urandom_range(0, 2))
			lines.push_back(LN_OTHER);
		if ($urandom_range(5) == 0)
			lines.push_back(LN_EMPTY);
		if (broken) begin
			case ($urandom_range(2))
				0: lines.delete($urandom_range(lines.size() - 1));
				1: lines.push_back(lines[$urandom_range(lines.size() - 1)]);
				default: lines.push_back(LN_GARBAGE);
			endcase
		end
		for (int i = lines.size() - 1; i > 0; i--) begin
			j = $urandom_range(i);
			t = lines[i];
			lines[i] = lines[j];
			lines[j] = t;
		end
		foreach (lines[i])
			put_line(lines[i]);
		text_q.push_back(CH_NL);
		if ($urandom_range(3) == 0)
			text_q.push_back(CH_NL);
	endtask

	task automatic random_stream();
		if ($urandom_range(4) == 0)
			text_q.push_back(CH_NL);
		repeat ($urandom_range(1, 3))
			put_record($urandom_range(99) < 15);
		// cut the tail now and then so the stream ends inside a record
		if ($urandom_range(6) == 0) begin
			repeat ($urandom_range(1, 6))
				if (text_q.size() > 1)
					void'(text_q.pop_back());
		end
		send_stream();
	endtask

	initial begin
		int mark;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tlast    = 1'b0;
		cfg_we     = 1'b0;
		cfg_wdata  = 1'b0;
		calm       = 1'b0;
		mode_now   = 1'b0;
		bytes_sent = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// normal mode
		directed("Package: foo\nVersion: 1.0\n\n");
		put_text("\n\nPackage:\t");
		text_q.push_back(8'h0B);
		text_q.push_back(8'h0C);
		text_q.push_back(CH_CR);
		directed("bar\nDescription: x\nVersion:  2\n\n\n");
		directed("Package:\nPackage: y\nVersion: 3\nStatus: install ok\n\n");
		directed(" Package: z\nPack: q\nPackage: r\nVersi\nVersion: 4\n\n");
		directed("Version: 1\n\nPackage: a\nVersion: 1\n\n");
		directed("Package: a\n\n");
		directed("Package: a\nPackage: b\n");
		directed("Package: a\nVersion: 1\nVersion: 2\n");
		directed("Package: a\nVersion: 1");
		directed("\n\n");
		directed("Pack");
		put_text("Package: ");
		text_q.push_back(8'h00);
		text_q.push_back(8'hFF);
		put_text("\nVersion: ");
		text_q.push_back(8'h80);
		text_q.push_back(8'h7F);
		directed("\n\n");

		// installed-status mode
		set_mode(1'b1);
		directed("Package: a\nStatus: install ok installed\n\n");
		directed("Package: b\nVersion: 9\n\nPackage: c\nStatus: install hold\nVersion: 1\n\n");
		directed("Package: d\nStatus: install ok\nStatus: install ok\n");
		directed("Status: install ok\n\n");
		directed("Package: e\nStatus: deinstall ok\n\nPackage: f\nStatus: install \n\n");

		mark = bytes_sent;
		for (int k = 0; k < 5; k++) begin
			set_mode(k[0]);
			calm = (k == 2);
			mark = bytes_sent;
			while (bytes_sent - mark < 40)
				random_stream();
		end
		calm = 1'b0;

		s_tvalid = 1'b0;
		wait (records_open == 0);
		repeat (20) @(posedge clk);
		if (fails == 0 && records_open == 0)
			$display("package_stanza_field_locator_unit regression: pass");
		else
			$display("package_stanza_field_locator_unit regression: fail");
		$finish;
	end

endmodule
